FILE: rtl/dhf_pkg.sv
package dhf_pkg;

  // Sizes of the pixel path and of the counters.
  localparam int unsigned DISP_W     = 16;
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [DIM_W-1:0]         dim_t;

  // Write port of the line store.
  typedef struct packed {
    logic  we;
    col_t  addr;
    disp_t data;
  } ls_wr_t;

  // Contents of the working stage between input and result registers.
  typedef struct packed {
    disp_t pix;
    col_t  col;
    logic  first_col;
    logic  row_nz;
    logic  row_end;
    logic  frame_end;
  } work_t;

endpackage

FILE: rtl/dhf_line_store.sv
module dhf_line_store (
  input  logic           clk_i,
  input  logic           rd_en_i,
  input  dhf_pkg::col_t  rd_addr_i,
  output dhf_pkg::disp_t rd_data_o,
  input  dhf_pkg::ls_wr_t wr_i
);
  import dhf_pkg::*;

  // One row of filled pixels; its contents are undefined until written.
  disp_t mem [MAX_WIDTH];
  disp_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.we && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/disparity_hole_fill.sv
// A result passes through the input register, then the result register, and waits
// only while the output stalls. Throughput: one pixel per cycle while the output does not
// stall; the only loop is the held-value update in the working stage, and the line store
// is read at acceptance and written when the pixel leaves the working stage.
// Reset: counters, held value, valid flags and the configuration registers are cleared
// asynchronously (width 640, height 480); the line store is not cleared and needs no pass.
module disparity_hole_fill (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dhf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dhf_pkg::DIM_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [dhf_pkg::DISP_W-1:0]   disparity_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dhf_pkg::DISP_W-1:0]   disparity_out_o,
  output logic                                row_end_o,
  output logic                                frame_end_o
);
  import dhf_pkg::*;

  dim_t   width_q, height_q;
  dim_t   width_eff, height_eff;
  col_t   col_q, col_d;
  row_t   row_q, row_d;
  logic   last_col, last_row;
  logic   in_acc, s1_adv, out_free;
  logic   s1_valid_q;
  work_t  s1_q, s1_d;
  disp_t  held_q, held_d;
  disp_t  above;
  disp_t  result;
  logic   out_valid_q;
  disp_t  out_disp_q;
  logic   out_row_end_q, out_frame_end_q;
  ls_wr_t ls_wr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to the supported range.
  always_comb begin
    if (width_q == '0) begin
      width_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
    if (height_q == '0) begin
      height_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
  end

  // Handshake: the working stage moves on whenever the result register can take it.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Raster position of the incoming pixel.
  assign last_col = (DIM_W'(col_q) + DIM_W'(1)) >= width_eff;
  assign last_row = (DIM_W'(row_q) + DIM_W'(1)) >= height_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input register of the working stage.
  always_comb begin
    s1_d.pix       = disparity_in_i;
    s1_d.col       = col_q;
    s1_d.first_col = (col_q == '0);
    s1_d.row_nz    = (row_q != '0);
    s1_d.row_end   = last_col;
    s1_d.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Line store of the previous filled row, read at acceptance.
  dhf_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (above),
    .wr_i      (ls_wr)
  );

  // Fill: a valid pixel passes and is held; an invalid one takes the held value,
  // or the pixel above when nothing valid is held and the pixel above is positive.
  always_comb begin
    held_d = s1_q.first_col ? s1_q.pix : held_q;
    if (s1_q.pix[DISP_W-1]) begin
      if (held_d[DISP_W-1] && s1_q.row_nz && !above[DISP_W-1] && (above != '0)) begin
        held_d = above;
      end
      result = held_d;
    end else begin
      held_d = s1_q.pix;
      result = s1_q.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (s1_adv) begin
      held_q <= held_d;
    end
  end

  assign ls_wr.we   = s1_adv;
  assign ls_wr.addr = s1_q.col;
  assign ls_wr.data = result;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_disp_q      <= result;
      out_row_end_q   <= s1_q.row_end;
      out_frame_end_q <= s1_q.frame_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign disparity_out_o = out_disp_q;
  assign row_end_o       = out_row_end_q;
  assign frame_end_o     = out_frame_end_q;

`ifndef SYNTHESIS
  // The last pixel of a frame is always the last pixel of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // The input side never stalls while the working stage is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty working stage");

  // A valid pixel leaving the working stage becomes the held value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_q.pix[DISP_W-1] |=> held_q == $past(s1_q.pix))
    else $error("held value not updated by a valid pixel");
`endif

endmodule

FILE: tb/disparity_hole_fill_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the hole filler, predicts every filled pixel and
// compares the results in order.
module disparity_hole_fill_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dhf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  dhf_pkg::dim_t                 cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  dhf_pkg::disp_t                disparity_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  dhf_pkg::disp_t                disparity_out_i,
  input  logic                          row_end_i,
  input  logic                          frame_end_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   fills_pending_o,
  output int unsigned                   results_checked_o,
  output int unsigned                   above_fills_o
);
  import dhf_pkg::*;

  typedef struct packed {
    disp_t disp;
    logic  row_end;
    logic  frame_end;
  } fill_result_t;

  // Private copy of the block's state and registers.
  disp_t        prev_row [MAX_WIDTH];
  disp_t        held_disp;
  col_t         col_cnt;
  row_t         row_cnt;
  dim_t         width_reg;
  dim_t         height_reg;
  fill_result_t expected_fills [$];

  // A zero dimension acts as one, anything above the maximum as the maximum.
  function automatic int unsigned eff_dim(input dim_t v, input int unsigned limit);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > limit) begin
      return limit;
    end
    return int'(v);
  endfunction

  // Fills one pixel and advances the raster position.
  function automatic fill_result_t fill_pixel(input disp_t pix);
    int unsigned  w;
    int unsigned  h;
    fill_result_t r;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (col_cnt == '0) begin
      held_disp = pix;
    end
    if (pix < 0) begin
      // Fall back on the filled row above only when nothing valid is held.
      if (held_disp < 0 && row_cnt != '0 && prev_row[col_cnt] > 0) begin
        held_disp = prev_row[col_cnt];
        above_fills_o++;
      end
      r.disp = held_disp;
    end else begin
      held_disp = pix;
      r.disp = pix;
    end
    prev_row[col_cnt] = r.disp;
    r.row_end = (col_cnt + 1 >= w);
    r.frame_end = r.row_end && (row_cnt + 1 >= h);
    if (r.row_end) begin
      col_cnt = '0;
      row_cnt = r.frame_end ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return r;
  endfunction

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    mismatch_count_o++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    fill_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        prev_row[i] = '0;
      end
      held_disp = '0;
      col_cnt = '0;
      row_cnt = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      expected_fills.delete();
      mismatch_count_o = 0;
      results_checked_o = 0;
      above_fills_o = 0;
    end else begin
      // Register writes only happen while no pixel is in flight.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_reg = cfg_wdata_i;
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      // Compare a result transaction with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (expected_fills.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result transaction with no pixel pending, expected none, actual %0d",
                   $time, disparity_out_i);
        end else begin
          want = expected_fills.pop_front();
          results_checked_o++;
          if (disparity_out_i !== want.disp) begin
            report_field("disparity_out", want.disp, disparity_out_i);
          end
          if (row_end_i !== want.row_end) begin
            report_field("row_end", want.row_end, row_end_i);
          end
          if (frame_end_i !== want.frame_end) begin
            report_field("frame_end", want.frame_end, frame_end_i);
          end
        end
      end
      // Predict the result of an accepted pixel transaction.
      if (in_valid_i && !in_stall_i) begin
        expected_fills.push_back(fill_pixel(disparity_in_i));
      end
    end
    fills_pending_o = expected_fills.size();
  end

endmodule

FILE: tb/disparity_hole_fill_tb.sv
`timescale 1ns / 1ps

module disparity_hole_fill_tb;
  import dhf_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 350;
  localparam int unsigned QUIET_PIXELS  = 150;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_IMAGE_WIDTH;
  dim_t                 cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  disp_t                disparity_in_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  disp_t                disparity_out_o;
  logic                 row_end_o;
  logic                 frame_end_o;

  int unsigned mismatches;
  int unsigned fills_pending;
  int unsigned results_checked;
  int unsigned above_fills;

  // Stimulus bookkeeping: raster position as the block should see it.
  dim_t        cur_width = WIDTH_RESET;
  dim_t        cur_height = HEIGHT_RESET;
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;
  int unsigned pixels_sent = 0;
  int unsigned dim_writes = 0;
  int unsigned hole_pct = 40;
  int unsigned gap_pct = 15;
  int unsigned cycle_count = 0;
  logic        quiet = 1'b0;

  // Holes at the first row, at row starts, and fills from above, one with
  // a zero above that must not be used.
  disp_t corner_px [12] = '{-5, -3, 7, -1, 0, 1, -6, 32767, -1, -2, -3, -4};

  disparity_hole_fill u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .disparity_in_i (disparity_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .disparity_out_o(disparity_out_o),
    .row_end_o      (row_end_o),
    .frame_end_o    (frame_end_o)
  );

  disparity_hole_fill_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .disparity_in_i   (disparity_in_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .disparity_out_i  (disparity_out_o),
    .row_end_i        (row_end_o),
    .frame_end_i      (frame_end_o),
    .mismatch_count_o (mismatches),
    .fills_pending_o  (fills_pending),
    .results_checked_o(results_checked),
    .above_fills_o    (above_fills)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, fills_pending);
      $display("disparity_hole_fill_tb: FAIL");
      $finish;
    end
  end

  // The result side stalls in random bursts until the quiet tail of the run.
  initial begin : result_stall_gen
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      n = $urandom_range(1, 24);
      repeat (n) @(posedge clk_i);
    end
  end

  function automatic int unsigned clamp_dim(input dim_t v, input int unsigned limit);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  // Random disparity; hole_chance is the percentage of invalid pixels.
  function automatic disp_t rand_disp(input int unsigned hole_chance);
    if ($urandom_range(0, 99) < hole_chance) begin
      case ($urandom_range(0, 7))
        0: return disp_t'(-1);
        1: return disp_t'(16'h8000);
        default: return disp_t'({1'b1, 15'($urandom)});
      endcase
    end
    case ($urandom_range(0, 7))
      0: return '0;
      1: return disp_t'(1);
      2: return disp_t'(16'h7fff);
      default: return disp_t'({1'b0, 15'($urandom)});
    endcase
  endfunction

  // Sends one pixel transaction, possibly after a gap, and tracks the position.
  task automatic send_pixel(input disp_t value);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    disparity_in_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
    if (pos_col + 1 >= clamp_dim(cur_width, MAX_WIDTH)) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= clamp_dim(cur_height, MAX_HEIGHT)) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  // Holds the sender back until every pending result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fills_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dims(input dim_t w, input dim_t h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_width = w;
    cur_height = h;
    dim_writes++;
  endtask

  // Runs on to the end of the current frame, or through a whole one.
  task automatic finish_frame();
    do begin
      send_pixel(rand_disp(hole_pct));
    end while (pos_col != 0 || pos_row != 0);
  endtask

  initial begin : stimulus
    int unsigned random_base;
    int unsigned n;
    dim_t        w;
    dim_t        h;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset dimensions: one full row of 640, then narrow mid-frame past the
    // current column and cut the frame short.
    repeat (650) send_pixel(rand_disp(hole_pct));
    wait_drained();
    write_dims(dim_t'(4), dim_t'(3));
    finish_frame();

    // Small frame with hand-picked holes.
    wait_drained();
    write_dims(dim_t'(4), dim_t'(3));
    foreach (corner_px[i]) begin
      send_pixel(corner_px[i]);
    end

    // The top of the tallest single column, broken off by the next change.
    wait_drained();
    write_dims(dim_t'(1), dim_t'(MAX_HEIGHT));
    hole_pct = 60;
    repeat (40) send_pixel(rand_disp(hole_pct));

    // Zero dimensions act as a one-pixel frame.
    wait_drained();
    write_dims('0, '0);
    repeat (4) send_pixel(rand_disp(hole_pct));

    // Oversized dimensions clamp; then shrink mid-frame.
    wait_drained();
    write_dims('1, '1);
    repeat (5) send_pixel(rand_disp(hole_pct));
    wait_drained();
    write_dims(dim_t'(3), dim_t'(2));
    finish_frame();

    // Random frames of small sizes, some broken off by a mid-frame change.
    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_PIXELS) begin
      wait_drained();
      w = ($urandom_range(0, 15) == 0) ? '0 : dim_t'($urandom_range(1, 16));
      h = ($urandom_range(0, 15) == 0) ? '0 : dim_t'($urandom_range(1, 6));
      write_dims(w, h);
      hole_pct = $urandom_range(0, 90);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
      quiet = (pixels_sent - random_base + QUIET_PIXELS > RANDOM_PIXELS);
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 20);
        repeat (n) send_pixel(rand_disp(hole_pct));
      end else begin
        finish_frame();
      end
    end

    quiet = 1'b1;
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d pixels over %0d dimension settings: reset, zero, one, maximum,",
             pixels_sent, dim_writes);
    $display("oversized and mid-frame changes; %0d results compared, %0d filled from above.",
             results_checked, above_fills);
    if (mismatches == 0) begin
      $display("disparity_hole_fill_tb: PASS");
    end else begin
      $display("disparity_hole_fill_tb: FAIL");
    end
    $finish;
  end

endmodule
